[rtl/core/fasta_json_record_splitter_top_assert.svh]
// Assertion macros for the FASTA record splitter checker
`ifndef FASTA_JSON_RECORD_SPLITTER_TOP_ASSERT_SVH
`define FASTA_JSON_RECORD_SPLITTER_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define FJRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fjrs checker: property failed");

// consequent must hold in the cycle after the antecedent
`define FJRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fjrs checker: property failed");

`endif

[rtl/core/fjrs_pkg.sv]
// Types, codes and constants shared by the FASTA record splitter
package fjrs_pkg;

    localparam int DEPTH_MAX_DEF = 255;
    localparam int QDEPTH        = 2;

    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;

    typedef enum logic [2:0] {
        KIND_ID      = 3'd0,
        KIND_PRE     = 3'd1,
        KIND_ANNOT   = 3'd2,
        KIND_DEF     = 3'd3,
        KIND_SEQ     = 3'd4,
        KIND_HDR_END = 3'd5,
        KIND_REC_END = 3'd6
    } t_kind;

    typedef enum logic [7:0] {
        PH_WAIT  = 8'b0000_0001,
        PH_ID    = 8'b0000_0010,
        PH_IDSP  = 8'b0000_0100,
        PH_PRE   = 8'b0000_1000,
        PH_ANNOT = 8'b0001_0000,
        PH_DEFSP = 8'b0010_0000,
        PH_DEF   = 8'b0100_0000,
        PH_SEQ   = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      kind;
        logic       annotation_closed;
        logic       header_complete;
        logic       last_of_run;
    } t_out;

    // one queue entry: the one or two results caused by a single byte
    typedef struct packed {
        logic two;
        t_out res0;
        t_out res1;
    } t_entry;

    typedef struct packed {
        logic   valid;
        logic   full;
        t_entry head;
    } t_q_status;

endpackage

[rtl/core/fjrs_front.sv]
// Front end: accepts bytes, tracks header and sequence parsing, builds queue entries
module fjrs_front
    import fjrs_pkg::*;
#(
    parameter int DEPTH_MAX = DEPTH_MAX_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_in    i_in_data,
    input  logic   i_q_full,
    output logic   o_push,
    output t_entry o_entry
);

    localparam int DW = $clog2(DEPTH_MAX + 1);
    localparam logic [DW-1:0] DMAX = DW'(DEPTH_MAX);

    t_phase        r_phase, n_phase;
    logic          r_after_nl, n_after_nl;
    logic [DW-1:0] r_depth, n_depth;
    logic          r_quote, n_quote;
    logic          r_annot_ok, n_annot_ok;
    logic          r_hdr_done, n_hdr_done;
    logic          r_rec_open, n_rec_open;

    logic [7:0] b;
    logic       eol, starts, is_letter, last, accept;
    logic       m_valid, f_valid;
    t_out       m_res, f_res;

    assign b          = i_in_data.in_byte;
    assign last       = i_in_data.end_of_input;
    assign eol        = (b == CH_CR) || (b == CH_LF);
    assign starts     = (b == CH_GT) && r_after_nl;
    assign is_letter  = ((b >= CH_UC_A) && (b <= CH_UC_Z)) ||
                        ((b >= CH_LC_A) && (b <= CH_LC_Z));
    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_phase    = r_phase;
        n_depth    = r_depth;
        n_quote    = r_quote;
        n_annot_ok = r_annot_ok;
        n_hdr_done = r_hdr_done;
        n_rec_open = r_rec_open;
        m_valid    = 1'b0;
        m_res      = '{out_byte: b, kind: KIND_ID, annotation_closed: 1'b0,
                       header_complete: 1'b0, last_of_run: 1'b0};
        f_valid    = 1'b0;
        f_res      = '{out_byte: 8'd0, kind: KIND_REC_END, annotation_closed: 1'b0,
                       header_complete: 1'b0, last_of_run: 1'b1};

        case (r_phase)
            PH_WAIT: begin
                if (starts) begin
                    n_phase    = PH_ID;
                    n_depth    = '0;
                    n_quote    = 1'b0;
                    n_annot_ok = 1'b0;
                    n_hdr_done = 1'b0;
                    n_rec_open = 1'b1;
                end
            end
            PH_ID: begin
                if (eol) begin
                    m_valid                 = 1'b1;
                    m_res.out_byte          = 8'd0;
                    m_res.kind              = KIND_HDR_END;
                    m_res.annotation_closed = r_annot_ok;
                    n_hdr_done              = 1'b1;
                    n_phase                 = PH_SEQ;
                end else if (b == CH_SPACE) begin
                    n_phase = PH_IDSP;
                end else begin
                    m_valid    = 1'b1;
                    m_res.kind = KIND_ID;
                end
            end
            PH_IDSP, PH_PRE: begin
                if (eol) begin
                    m_valid                 = 1'b1;
                    m_res.out_byte          = 8'd0;
                    m_res.kind              = KIND_HDR_END;
                    m_res.annotation_closed = r_annot_ok;
                    n_hdr_done              = 1'b1;
                    n_phase                 = PH_SEQ;
                end else if ((b == CH_SPACE) && (r_phase == PH_IDSP)) begin
                    // skip separating spaces
                end else if (b == CH_LBRACE) begin
                    n_depth    = DW'(1);
                    n_quote    = 1'b0;
                    m_valid    = 1'b1;
                    m_res.kind = KIND_ANNOT;
                    n_phase    = PH_ANNOT;
                end else begin
                    m_valid    = 1'b1;
                    m_res.kind = KIND_PRE;
                    n_phase    = PH_PRE;
                end
            end
            PH_ANNOT: begin
                if (eol) begin
                    m_valid                 = 1'b1;
                    m_res.out_byte          = 8'd0;
                    m_res.kind              = KIND_HDR_END;
                    m_res.annotation_closed = r_annot_ok;
                    n_hdr_done              = 1'b1;
                    n_phase                 = PH_SEQ;
                end else begin
                    m_valid    = 1'b1;
                    m_res.kind = KIND_ANNOT;
                    if (b == CH_QUOTE) begin
                        n_quote = !r_quote;
                    end else if (!r_quote) begin
                        if (b == CH_LBRACE) begin
                            // saturate at the top depth
                            if (r_depth != DMAX) begin
                                n_depth = r_depth + DW'(1);
                            end
                        end else if (b == CH_RBRACE) begin
                            if (r_depth != '0) begin
                                n_depth = r_depth - DW'(1);
                            end
                            if (r_depth <= DW'(1)) begin
                                n_annot_ok = 1'b1;
                                n_phase    = PH_DEFSP;
                            end
                        end
                    end
                end
            end
            PH_DEFSP, PH_DEF: begin
                if (eol) begin
                    m_valid                 = 1'b1;
                    m_res.out_byte          = 8'd0;
                    m_res.kind              = KIND_HDR_END;
                    m_res.annotation_closed = r_annot_ok;
                    n_hdr_done              = 1'b1;
                    n_phase                 = PH_SEQ;
                end else if ((b == CH_SPACE) && (r_phase == PH_DEFSP)) begin
                    // skip separating spaces
                end else begin
                    m_valid    = 1'b1;
                    m_res.kind = KIND_DEF;
                    n_phase    = PH_DEF;
                end
            end
            PH_SEQ: begin
                if (starts) begin
                    // close the old record, then open the new one
                    m_valid                 = 1'b1;
                    m_res.out_byte          = 8'd0;
                    m_res.kind              = KIND_REC_END;
                    m_res.annotation_closed = r_annot_ok;
                    m_res.header_complete   = r_hdr_done;
                    n_phase                 = PH_ID;
                    n_depth                 = '0;
                    n_quote                 = 1'b0;
                    n_annot_ok              = 1'b0;
                    n_hdr_done              = 1'b0;
                    n_rec_open              = 1'b1;
                end else if (is_letter) begin
                    m_valid    = 1'b1;
                    m_res.kind = KIND_SEQ;
                end
            end
            default: begin
                n_phase = PH_WAIT;
            end
        endcase

        n_after_nl = (b == CH_LF);

        if (last) begin
            if (n_rec_open) begin
                f_valid                 = 1'b1;
                f_res.annotation_closed = n_annot_ok;
                f_res.header_complete   = n_hdr_done;
            end
            // back to the reset state
            n_phase    = PH_WAIT;
            n_after_nl = 1'b1;
            n_depth    = '0;
            n_quote    = 1'b0;
            n_annot_ok = 1'b0;
            n_hdr_done = 1'b0;
            n_rec_open = 1'b0;
        end
    end

    always_comb begin
        o_entry.two              = m_valid && f_valid;
        o_entry.res0             = m_valid ? m_res : f_res;
        o_entry.res0.last_of_run = !(m_valid && f_valid);
        o_entry.res1             = f_res;
        o_push                   = accept && (m_valid || f_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WAIT;
            r_after_nl <= 1'b1;
            r_depth    <= '0;
            r_quote    <= 1'b0;
            r_annot_ok <= 1'b0;
            r_hdr_done <= 1'b0;
            r_rec_open <= 1'b0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_after_nl <= n_after_nl;
            r_depth    <= n_depth;
            r_quote    <= n_quote;
            r_annot_ok <= n_annot_ok;
            r_hdr_done <= n_hdr_done;
            r_rec_open <= n_rec_open;
        end
    end

endmodule

[rtl/core/fjrs_queue.sv]
// Short entry queue between the front end and the output stage
module fjrs_queue
    import fjrs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_entry    i_entry,
    input  logic      i_pop,
    output t_q_status o_status
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_entry        r_mem [QDEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_status.valid = (r_count != '0);
    assign o_status.full  = (r_count == CW'(QDEPTH));
    assign o_status.head  = r_mem[r_rd];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && o_status.valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PW'(QDEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(QDEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

[rtl/core/fjrs_back.sv]
// Back end: unpacks queue entries into single items in the output register
module fjrs_back
    import fjrs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_status i_q,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out      o_out_data
);

    logic r_valid, n_valid;
    logic r_sub, n_sub;
    t_out r_data, n_data;
    logic can_load;

    assign can_load = !r_valid || i_out_ready;

    always_comb begin
        n_valid = r_valid;
        n_sub   = r_sub;
        n_data  = r_data;
        o_pop   = 1'b0;
        if (can_load) begin
            n_valid = i_q.valid;
            if (i_q.valid) begin
                if (i_q.head.two && !r_sub) begin
                    // first of two: hold the entry for its second item
                    n_data = i_q.head.res0;
                    n_sub  = 1'b1;
                end else begin
                    n_data = r_sub ? i_q.head.res1 : i_q.head.res0;
                    n_sub  = 1'b0;
                    o_pop  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sub   <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

[rtl/core/fasta_json_record_splitter_top.sv]
// Path: an accepted byte's items are written into the queue, then loaded into the output register.
// Throughput: one byte per cycle while the queue is not full; a byte causing two items
// gives them in turn, the single output register taking one item a cycle from the
// 2-entry queue while the output is ready. Bytes causing no item use no queue slot.
// Reset: synchronous, active low; clears parser state, queue and output register.
module fasta_json_record_splitter_top
    import fjrs_pkg::*;
#(
    parameter int DEPTH_MAX = DEPTH_MAX_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic      push, pop;
    t_entry    entry;
    t_q_status q_status;

    fjrs_front #(
        .DEPTH_MAX (DEPTH_MAX)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_status.full),
        .o_push     (push),
        .o_entry    (entry)
    );

    fjrs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (entry),
        .i_pop    (pop),
        .o_status (q_status)
    );

    fjrs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

[rtl/core/fjrs_checker.sv]
// Port-level checker for the FASTA record splitter, bound to the top level
`include "fasta_json_record_splitter_top_assert.svh"

module fjrs_checker
    import fjrs_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    logic in_stall, out_stall, out_marker;

    assign in_stall   = i_in_valid && !o_in_ready;
    assign out_stall  = o_out_valid && !i_out_ready;
    assign out_marker = (o_out_data.kind == KIND_HDR_END) || (o_out_data.kind == KIND_REC_END);

    `FJRS_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, in_stall, i_in_valid && $stable(i_in_data))
    `FJRS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_out_data))
    `FJRS_ASSERT_NOW(a_hc_rec_end, i_clk, i_rst_n, o_out_valid && o_out_data.header_complete, o_out_data.kind == KIND_REC_END)
    `FJRS_ASSERT_NOW(a_ac_markers, i_clk, i_rst_n, o_out_valid && o_out_data.annotation_closed, out_marker)
    `FJRS_ASSERT_NOW(a_marker_zero, i_clk, i_rst_n, o_out_valid && out_marker, o_out_data.out_byte == 8'd0)

endmodule

bind fasta_json_record_splitter_top fjrs_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
